@@ src/xcfr_pkg.sv @@
// shared types and constants for the xor checked frame receiver
package xcfr_pkg;

    localparam int BLOCK_BYTES_DEF = 4;
    localparam int BLOCK_COUNT_DEF = 4;
    localparam int BLOCK_COUNT_MAX = 16;

    localparam int BYTE_W      = 8;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int PLEN_W      = 2;
    localparam int LEFT_W      = 3;
    localparam int LANES       = 4;
    localparam int LANE_W      = $clog2(LANES);
    localparam int DATA_W      = LANES * BYTE_W;
    localparam int BLK_IDX_W   = $clog2(BLOCK_COUNT_MAX);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] HEADER_ID_RST      = 8'd0;
    localparam logic [PLEN_W-1:0] PAYLOAD_LENGTH_RST = 2'd3;
    localparam logic [BYTE_W-1:0] BYTE_TIMEOUT_RST   = 8'd3;

    typedef enum logic [OP_W-1:0] {
        OP_RX   = 2'd0,
        OP_TICK = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_ID      = 2'd0,
        CFG_PAYLOAD_LENGTH = 2'd1,
        CFG_BYTE_TIMEOUT   = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FRAME = 1'b1
    } state_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [BLK_IDX_W-1:0] block;
        logic [LANE_W-1:0]    lane;
        logic [BYTE_W-1:0]    wr_byte;
        logic                 ring_empty;
        logic                 frame_accepted;
        logic                 frame_rejected;
    } cmd_t;

endpackage

@@ src/xcfr_ifs.sv @@
// channel interfaces for items, results and configuration writes
interface xcfr_item_if;
    logic                          valid;
    logic                          ready;
    logic [xcfr_pkg::OP_W-1:0]     operation;
    logic [xcfr_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, operation, rx_byte, input ready);
    modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface xcfr_result_if;
    logic                          valid;
    logic                          ready;
    logic [xcfr_pkg::DATA_W-1:0]   block_data;
    logic                          ring_empty;
    logic                          frame_accepted;
    logic                          frame_rejected;

    modport source (output valid, block_data, ring_empty, frame_accepted, frame_rejected,
                    input ready);
    modport sink   (input valid, block_data, ring_empty, frame_accepted, frame_rejected,
                    output ready);
endinterface

interface xcfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [xcfr_pkg::CFG_IDX_W-1:0] index;
    logic [xcfr_pkg::BYTE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/xor_checked_frame_receiver.sv @@
// top level of the xor checked frame receiver
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    operation, rx_byte
//  out_ch    out  valid/ready    block_data, ring_empty, frame_accepted, frame_rejected
//  cfg_ch    in   valid/ready    index, data (header_id, payload_length, byte_timeout)
//
// one item per cycle while the command queue has room; a result passes through the command
// queue and then the back register after its transfer (the front decision is combinational)
// rst_n clears frame state, ring indices, queue and block store valid bits at once
// the two entry command queue absorbs output stalls; in_ch.ready drops when it is full
// cfg_ch is always ready
module xor_checked_frame_receiver #(
    parameter int BLOCK_BYTES = xcfr_pkg::BLOCK_BYTES_DEF,
    parameter int BLOCK_COUNT = xcfr_pkg::BLOCK_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    xcfr_item_if.sink     in_ch,
    xcfr_result_if.source out_ch,
    xcfr_cfg_if.sink      cfg_ch
);

    logic           push_valid;
    logic           push_ready;
    xcfr_pkg::cmd_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    xcfr_pkg::cmd_t pop_data;

    xcfr_front #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (in_ch),
        .cfg        (cfg_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    xcfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    xcfr_back #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (out_ch)
    );

endmodule

@@ src/xcfr_front.sv @@
// front end: config registers, frame tracking and command generation
module xcfr_front #(
    parameter int BLOCK_BYTES = xcfr_pkg::BLOCK_BYTES_DEF,
    parameter int BLOCK_COUNT = xcfr_pkg::BLOCK_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    xcfr_item_if.sink            item,
    xcfr_cfg_if.sink             cfg,
    output logic                 push_valid,
    input  logic                 push_ready,
    output xcfr_pkg::cmd_t       push_data
);

    localparam int BLK_W    = $clog2(BLOCK_COUNT);
    localparam int OFF_W    = $clog2(BLOCK_BYTES + 1);
    localparam int LANE_LIM = (BLOCK_BYTES < xcfr_pkg::LANES) ? BLOCK_BYTES : xcfr_pkg::LANES;

    logic [xcfr_pkg::BYTE_W-1:0] header_id_reg;
    logic [xcfr_pkg::PLEN_W-1:0] payload_length_reg;
    logic [xcfr_pkg::BYTE_W-1:0] byte_timeout_reg;

    xcfr_pkg::state_t            state_reg, state_next;
    logic [BLK_W-1:0]            write_blk_reg, write_blk_next;
    logic [BLK_W-1:0]            read_blk_reg, read_blk_next;
    logic [OFF_W-1:0]            offset_reg, offset_next;
    logic [xcfr_pkg::LEFT_W-1:0] left_reg, left_next;
    logic [xcfr_pkg::BYTE_W-1:0] tcount_reg, tcount_next;
    logic [xcfr_pkg::BYTE_W-1:0] xor_reg, xor_next;

    logic                        accept;
    logic [xcfr_pkg::LEFT_W-1:0] left_dec;
    logic                        is_header;
    logic                        is_last;
    logic                        sum_ok;
    logic                        lane_ok;
    xcfr_pkg::cmd_t              cmd;

    assign accept     = item.valid && push_ready;
    assign item.ready = push_ready;
    assign cfg.ready  = 1'b1;
    assign push_valid = item.valid;
    assign push_data  = cmd;

    assign left_dec  = left_reg - xcfr_pkg::LEFT_W'(1);
    assign is_header = item.rx_byte == header_id_reg;
    assign is_last   = left_dec == '0;
    assign sum_ok    = xor_reg == item.rx_byte;
    assign lane_ok   = offset_reg < OFF_W'(LANE_LIM);

    function automatic logic [BLK_W-1:0] next_blk(input logic [BLK_W-1:0] b);
        next_blk = (b == BLK_W'(BLOCK_COUNT - 1)) ? '0 : b + BLK_W'(1);
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_id_reg      <= xcfr_pkg::HEADER_ID_RST;
            payload_length_reg <= xcfr_pkg::PAYLOAD_LENGTH_RST;
            byte_timeout_reg   <= xcfr_pkg::BYTE_TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                xcfr_pkg::CFG_HEADER_ID:      header_id_reg      <= cfg.data;
                xcfr_pkg::CFG_PAYLOAD_LENGTH:
                    payload_length_reg <= cfg.data[xcfr_pkg::PLEN_W-1:0];
                xcfr_pkg::CFG_BYTE_TIMEOUT:   byte_timeout_reg   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (item.operation)
            xcfr_pkg::OP_RX:
            begin
                if (state_reg == xcfr_pkg::ST_IDLE)
                begin
                    if (is_header)
                        state_next = xcfr_pkg::ST_FRAME;
                end
                else if (is_last)
                begin
                    state_next = xcfr_pkg::ST_IDLE;
                end
            end
            xcfr_pkg::OP_TICK:
            begin
                if (tcount_reg == xcfr_pkg::BYTE_W'(1))
                    state_next = xcfr_pkg::ST_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    // datapath and command
    always_comb
    begin
        write_blk_next = write_blk_reg;
        read_blk_next  = read_blk_reg;
        offset_next    = offset_reg;
        left_next      = left_reg;
        tcount_next    = tcount_reg;
        xor_next       = xor_reg;

        cmd                = '0;
        cmd.wr_byte        = item.rx_byte;
        cmd.block          = xcfr_pkg::BLK_IDX_W'(write_blk_reg);
        cmd.ring_empty     = read_blk_reg == write_blk_reg;

        unique case (item.operation)
            xcfr_pkg::OP_RX:
            begin
                if (state_reg == xcfr_pkg::ST_IDLE)
                begin
                    if (is_header)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.lane    = '0;
                        offset_next = OFF_W'(1);
                        left_next   = xcfr_pkg::LEFT_W'(payload_length_reg)
                                    + xcfr_pkg::LEFT_W'(1);
                        tcount_next = byte_timeout_reg;
                        xor_next    = item.rx_byte;
                    end
                end
                else
                begin
                    left_next = left_dec;
                    if (!is_last)
                    begin
                        cmd.wr_en   = lane_ok;
                        cmd.lane    = offset_reg[xcfr_pkg::LANE_W-1:0];
                        if (offset_reg < OFF_W'(BLOCK_BYTES))
                            offset_next = offset_reg + OFF_W'(1);
                        tcount_next = byte_timeout_reg;
                        xor_next    = xor_reg ^ item.rx_byte;
                    end
                    else
                    begin
                        if (sum_ok)
                        begin
                            write_blk_next     = next_blk(write_blk_reg);
                            cmd.frame_accepted = 1'b1;
                        end
                        else
                        begin
                            cmd.frame_rejected = 1'b1;
                        end
                        offset_next = '0;
                        tcount_next = '0;
                    end
                end
            end
            xcfr_pkg::OP_TICK:
            begin
                if (tcount_reg != '0)
                    tcount_next = tcount_reg - xcfr_pkg::BYTE_W'(1);
            end
            xcfr_pkg::OP_POP:
            begin
                cmd.rd_en     = 1'b1;
                cmd.block     = xcfr_pkg::BLK_IDX_W'(read_blk_reg);
                read_blk_next = next_blk(read_blk_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xcfr_pkg::ST_IDLE;
            write_blk_reg <= '0;
            read_blk_reg  <= '0;
            offset_reg    <= '0;
            left_reg      <= '0;
            tcount_reg    <= '0;
            xor_reg       <= '0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            write_blk_reg <= write_blk_next;
            read_blk_reg  <= read_blk_next;
            offset_reg    <= offset_next;
            left_reg      <= left_next;
            tcount_reg    <= tcount_next;
            xor_reg       <= xor_next;
        end
    end

endmodule

@@ src/xcfr_queue.sv @@
// short command queue between front and back
module xcfr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  xcfr_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output xcfr_pkg::cmd_t pop_data
);

    localparam int PTR_W = $clog2(xcfr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(xcfr_pkg::QUEUE_DEPTH + 1);

    xcfr_pkg::cmd_t   entry_reg [xcfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(xcfr_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign push_ready = count_reg != CNT_W'(xcfr_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/xcfr_back.sv @@
// back end: block store writes, block reads and result register
module xcfr_back #(
    parameter int BLOCK_COUNT = xcfr_pkg::BLOCK_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  xcfr_pkg::cmd_t pop_data,
    xcfr_result_if.source  result
);

    localparam int BLK_W = $clog2(BLOCK_COUNT);

    logic [xcfr_pkg::DATA_W-1:0] store_mem [BLOCK_COUNT];
    logic [xcfr_pkg::LANES-1:0]  lane_valid_reg [BLOCK_COUNT];

    logic                        out_valid_reg;
    logic [xcfr_pkg::DATA_W-1:0] rd_data_reg;
    logic [xcfr_pkg::DATA_W-1:0] rd_mask_reg, rd_mask_next;
    logic                        empty_reg;
    logic                        acc_reg;
    logic                        rej_reg;

    logic                        take;
    logic [BLK_W-1:0]            blk;

    assign pop_ready = !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;
    assign blk       = pop_data.block[BLK_W-1:0];

    assign result.valid          = out_valid_reg;
    assign result.block_data     = rd_data_reg & rd_mask_reg;
    assign result.ring_empty     = empty_reg;
    assign result.frame_accepted = acc_reg;
    assign result.frame_rejected = rej_reg;

    // never written lanes read as zero
    always_comb
    begin
        rd_mask_next = '0;
        for (int k = 0; k < xcfr_pkg::LANES; k++)
        begin
            rd_mask_next[k*xcfr_pkg::BYTE_W +: xcfr_pkg::BYTE_W] =
                {xcfr_pkg::BYTE_W{pop_data.rd_en && lane_valid_reg[blk][k]}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pop_data.wr_en)
            store_mem[blk][pop_data.lane*xcfr_pkg::BYTE_W +: xcfr_pkg::BYTE_W] <= pop_data.wr_byte;
        if (take)
        begin
            rd_data_reg <= store_mem[blk];
            rd_mask_reg <= rd_mask_next;
            empty_reg   <= pop_data.ring_empty;
            acc_reg     <= pop_data.frame_accepted;
            rej_reg     <= pop_data.frame_rejected;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int b = 0; b < BLOCK_COUNT; b++)
                lane_valid_reg[b] <= '0;
        end
        else
        begin
            if (take)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (take && pop_data.wr_en)
                lane_valid_reg[blk][pop_data.lane] <= 1'b1;
        end
    end

endmodule

@@ sim/xor_checked_frame_receiver_tb.sv @@
// self-checking testbench for the xor checked frame receiver
module xor_checked_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_BYTES  = xcfr_pkg::BLOCK_BYTES_DEF;
    localparam int RING_BLOCKS = xcfr_pkg::BLOCK_COUNT_DEF;
    localparam int STORE_BYTES = RING_BYTES * RING_BLOCKS;
    localparam int HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES = 6;

    localparam logic [xcfr_pkg::OP_W-1:0]      OP_SPARE  = 2'd3;
    localparam logic [xcfr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [xcfr_pkg::DATA_W-1:0] block_data;
        logic                        ring_empty;
        logic                        frame_accepted;
        logic                        frame_rejected;
    } step_outcome_t;

    class deframer_scoreboard;
        logic [xcfr_pkg::BYTE_W-1:0] header_id;
        logic [xcfr_pkg::PLEN_W-1:0] payload_len;
        logic [xcfr_pkg::BYTE_W-1:0] byte_timeout;

        logic                        in_frame;
        int unsigned                 wr_blk;
        int unsigned                 rd_blk;
        int unsigned                 offset;
        logic [xcfr_pkg::LEFT_W-1:0] bytes_left;
        logic [xcfr_pkg::BYTE_W-1:0] timeout_count;
        logic [xcfr_pkg::BYTE_W-1:0] running_xor;
        logic [xcfr_pkg::BYTE_W-1:0] ring_store [STORE_BYTES];

        step_outcome_t     expected_outcomes [$];
        int                errors;

        function new();
            header_id     = xcfr_pkg::HEADER_ID_RST;
            payload_len   = xcfr_pkg::PAYLOAD_LENGTH_RST;
            byte_timeout  = xcfr_pkg::BYTE_TIMEOUT_RST;
            in_frame      = 1'b0;
            wr_blk        = 0;
            rd_blk        = 0;
            offset        = 0;
            bytes_left    = '0;
            timeout_count = '0;
            running_xor   = '0;
            errors        = 0;
            foreach (ring_store[i])
                ring_store[i] = '0;
        endfunction

        function void set_reg(logic [xcfr_pkg::CFG_IDX_W-1:0] idx,
                              logic [xcfr_pkg::BYTE_W-1:0] value);
            case (idx)
                xcfr_pkg::CFG_HEADER_ID:      header_id    = value;
                xcfr_pkg::CFG_PAYLOAD_LENGTH: payload_len  = value[xcfr_pkg::PLEN_W-1:0];
                xcfr_pkg::CFG_BYTE_TIMEOUT:   byte_timeout = value;
                default: ;
            endcase
        endfunction

        function void put_byte(int unsigned off, logic [xcfr_pkg::BYTE_W-1:0] value);
            if (off < RING_BYTES)
                ring_store[wr_blk * RING_BYTES + off] = value;
        endfunction

        function void note_transfer(logic [xcfr_pkg::OP_W-1:0] op,
                                    logic [xcfr_pkg::BYTE_W-1:0] rx);
            step_outcome_t o;
            o = '0;
            o.ring_empty = (rd_blk == wr_blk);
            case (op)
                xcfr_pkg::OP_RX:
                    if (!in_frame) begin
                        if (rx == header_id) begin
                            put_byte(0, rx);
                            offset        = 1;
                            bytes_left    = xcfr_pkg::LEFT_W'(payload_len) + 3'd1;
                            timeout_count = byte_timeout;
                            running_xor   = rx;
                            in_frame      = 1'b1;
                        end
                    end else begin
                        bytes_left = bytes_left - 3'd1;
                        if (bytes_left != 0) begin
                            put_byte(offset, rx);
                            if (offset < RING_BYTES)
                                offset++;
                            timeout_count = byte_timeout;
                            running_xor   = running_xor ^ rx;
                        end else begin
                            if (running_xor == rx) begin
                                wr_blk = (wr_blk + 1) % RING_BLOCKS;
                                o.frame_accepted = 1'b1;
                            end else begin
                                o.frame_rejected = 1'b1;
                            end
                            offset        = 0;
                            timeout_count = '0;
                            in_frame      = 1'b0;
                        end
                    end
                xcfr_pkg::OP_TICK:
                    if (timeout_count > 0) begin
                        timeout_count--;
                        if (timeout_count == 0)
                            in_frame = 1'b0;
                    end
                xcfr_pkg::OP_POP: begin
                    for (int k = 0; k < xcfr_pkg::LANES && k < RING_BYTES; k++)
                        o.block_data[8*k +: 8] = ring_store[rd_blk * RING_BYTES + k];
                    rd_blk = (rd_blk + 1) % RING_BLOCKS;
                end
                default: ;
            endcase
            expected_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [xcfr_pkg::DATA_W-1:0] exp_v,
                                    logic [xcfr_pkg::DATA_W-1:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_outcome(step_outcome_t got);
            step_outcome_t exp_o;
            if (expected_outcomes.size() == 0) begin
                $error("result transfer with no item pending");
                errors++;
                return;
            end
            exp_o = expected_outcomes.pop_front();
            compare_field("block_data", exp_o.block_data, got.block_data);
            compare_field("ring_empty", xcfr_pkg::DATA_W'(exp_o.ring_empty),
                          xcfr_pkg::DATA_W'(got.ring_empty));
            compare_field("frame_accepted", xcfr_pkg::DATA_W'(exp_o.frame_accepted),
                          xcfr_pkg::DATA_W'(got.frame_accepted));
            compare_field("frame_rejected", xcfr_pkg::DATA_W'(exp_o.frame_rejected),
                          xcfr_pkg::DATA_W'(got.frame_rejected));
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   gaps_on;
    bit   stalls_on;
    bit   hold_request;

    logic [xcfr_pkg::BYTE_W-1:0] cur_header;
    logic [xcfr_pkg::PLEN_W-1:0] cur_plen;

    deframer_scoreboard sb;

    xcfr_item_if   item_if ();
    xcfr_result_if result_if ();
    xcfr_cfg_if    cfg_if ();

    xor_checked_frame_receiver u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (item_if),
        .out_ch (result_if),
        .cfg_ch (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        result_if.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_request) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end else begin
                result_if.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_outcome({result_if.block_data, result_if.ring_empty,
                              result_if.frame_accepted, result_if.frame_rejected});
    end

    task automatic send_item(logic [xcfr_pkg::OP_W-1:0] op, logic [xcfr_pkg::BYTE_W-1:0] rx);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.operation <= op;
        item_if.rx_byte   <= rx;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        sb.note_transfer(op, rx);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_transfer(logic [xcfr_pkg::CFG_IDX_W-1:0] idx,
                                logic [xcfr_pkg::BYTE_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic configure(logic [xcfr_pkg::BYTE_W-1:0] hdr, logic [xcfr_pkg::PLEN_W-1:0] plen,
                             logic [xcfr_pkg::BYTE_W-1:0] tmo, bit spare);
        wait_idle();
        cfg_transfer(xcfr_pkg::CFG_HEADER_ID, hdr);
        cfg_transfer(xcfr_pkg::CFG_PAYLOAD_LENGTH, xcfr_pkg::BYTE_W'(plen));
        cfg_transfer(xcfr_pkg::CFG_BYTE_TIMEOUT, tmo);
        if (spare)
            cfg_transfer(CFG_SPARE, ~hdr);
        cfg_if.valid <= 1'b0;
        cur_header = hdr;
        cur_plen   = plen;
    endtask

    // well-formed frame most of the time, with stray ticks, odd lengths and bad checksums
    task automatic send_frame(output int sent);
        int                          n;
        logic [xcfr_pkg::BYTE_W-1:0] sum;
        logic [xcfr_pkg::BYTE_W-1:0] b;
        n    = cur_plen;
        sent = 0;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, 3);
        sum = cur_header;
        send_item(xcfr_pkg::OP_RX, cur_header);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(xcfr_pkg::OP_TICK, 8'($urandom));
                sent++;
            end
            b   = 8'($urandom);
            sum = sum ^ b;
            send_item(xcfr_pkg::OP_RX, b);
        end
        if ($urandom_range(0, 4) == 0)
            sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_item(xcfr_pkg::OP_RX, sum);
        sent += n + 2;
    endtask

    task automatic run_phase(int target);
        int count;
        int sent;
        int pick;
        count = 0;
        while (count < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                send_frame(sent);
                count += sent;
            end else if (pick < 15) begin
                send_item(xcfr_pkg::OP_POP, 8'($urandom));
                count++;
            end else if (pick < 17) begin
                send_item(xcfr_pkg::OP_TICK, 8'($urandom));
                count++;
            end else if (pick < 19) begin
                send_item(xcfr_pkg::OP_RX, 8'($urandom));
                count++;
            end else begin
                send_item(OP_SPARE, 8'($urandom));
                count++;
            end
        end
    endtask

    initial
    begin
        sb                = new();
        rst_n             = 1'b0;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;
        hold_request      = 1'b0;
        cur_header        = xcfr_pkg::HEADER_ID_RST;
        cur_plen          = xcfr_pkg::PAYLOAD_LENGTH_RST;
        item_if.valid     = 1'b0;
        item_if.operation = xcfr_pkg::OP_RX;
        item_if.rx_byte   = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = xcfr_pkg::CFG_HEADER_ID;
        cfg_if.data       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, pop on empty ring, full frame, unused op, idle tick
        send_item(xcfr_pkg::OP_POP, 8'h00);
        send_item(xcfr_pkg::OP_RX, 8'h00);
        send_item(xcfr_pkg::OP_RX, 8'h11);
        send_item(xcfr_pkg::OP_RX, 8'h22);
        send_item(xcfr_pkg::OP_RX, 8'h33);
        send_item(xcfr_pkg::OP_RX, 8'h00);
        send_item(OP_SPARE, 8'hFF);
        send_item(xcfr_pkg::OP_TICK, 8'hFF);
        send_item(xcfr_pkg::OP_POP, 8'hA5);

        // zero payload length, zero timeout, ignored register index
        configure(8'hFF, 2'd0, 8'd0, 1'b1);
        send_item(xcfr_pkg::OP_RX, 8'hFF);
        send_item(xcfr_pkg::OP_RX, 8'hFF);
        send_item(xcfr_pkg::OP_RX, 8'hFF);
        send_item(xcfr_pkg::OP_TICK, 8'h00);
        send_item(xcfr_pkg::OP_TICK, 8'h00);
        send_item(xcfr_pkg::OP_TICK, 8'h00);
        send_item(xcfr_pkg::OP_RX, 8'h00);
        send_item(xcfr_pkg::OP_POP, 8'h00);

        // timeout mid-frame, then header value used as payload
        configure(8'hA5, 2'd2, 8'd1, 1'b0);
        send_item(xcfr_pkg::OP_RX, 8'hA5);
        send_item(xcfr_pkg::OP_RX, 8'h01);
        send_item(xcfr_pkg::OP_TICK, 8'h00);
        send_item(xcfr_pkg::OP_RX, 8'hA5);
        send_item(xcfr_pkg::OP_RX, 8'hA5);
        send_item(xcfr_pkg::OP_RX, 8'h5A);
        send_item(xcfr_pkg::OP_RX, 8'h5A);

        configure(8'h00, 2'd1, 8'd255, 1'b0);
        hold_request = 1'b1;
        run_phase(250);

        configure(8'hFF, 2'd3, 8'd1, 1'b0);
        run_phase(250);

        configure(8'($urandom), 2'd0, 8'd0, 1'b1);
        run_phase(200);

        configure(8'($urandom), 2'd2, 8'($urandom_range(2, 6)), 1'b0);
        run_phase(250);

        configure(8'($urandom), 2'($urandom_range(0, 3)), 8'($urandom_range(1, 255)), 1'b0);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_phase(300);

        wait_idle();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
